// ===== sv/windowed_fault_result_filter_unit_defines.svh =====
// assertion macros of the windowed fault result filter rtl, used by the back end
`ifndef WINDOWED_FAULT_RESULT_FILTER_UNIT_DEFINES_SVH
`define WINDOWED_FAULT_RESULT_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define WFRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wfrf check failed: same-cycle implication");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define WFRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wfrf check failed: next-cycle implication");

`endif

// ===== sv/wfrf_pkg.sv =====
// shared types and constants of the windowed fault result filter
`default_nettype none

package wfrf_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF   = 128;
  localparam int unsigned DEPTH_DEFAULT    = 20;
  localparam int unsigned PERCENT_FULL     = 100;
  // wide enough for limit * depth over the whole window range
  localparam int unsigned THR_W            = 16;
  localparam int unsigned QDEPTH           = 2;
  localparam int unsigned PADDR_W          = 6;
  localparam int unsigned PDATA_W          = 64;
  localparam int unsigned REG_IDX_W        = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_DEPTH    = 3'd1,
    REG_MODE     = 3'd2,
    REG_LIMIT_LO = 3'd3,
    REG_LIMIT_HI = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_SEQ  = 2'd2,
    MODE_OFF  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    JOB_RAW  = 2'd0,
    JOB_KEEP = 2'd1,
    JOB_PCT  = 2'd2,
    JOB_SEQ  = 2'd3
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCAN  = 2'd1,
    BK_JUDGE = 2'd2,
    BK_EMIT  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [3:0] channel;
    logic       test_failed;
  } in_item_t;

  typedef struct packed {
    logic filtered_failed;
    logic filter_applied;
  } out_item_t;

  typedef struct packed {
    logic         enable;
    logic [31:0]  mode_table;
    logic [127:0] limits;
  } cfg_t;

  typedef struct packed {
    job_kind_e        kind;
    logic [3:0]       channel;
    logic             test_failed;
    logic [THR_W-1:0] thr;
  } job_t;

endpackage

`default_nettype wire

// ===== sv/wfrf_front.sv =====
// front end: classifies each item into a job and precomputes its threshold
`default_nettype none

module wfrf_front #(
  parameter int unsigned NUM_CHANNELS = wfrf_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW   = wfrf_pkg::MAX_WINDOW_DEF
) (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wfrf_pkg::in_item_t                in_item_i,
  input  wfrf_pkg::cfg_t                    cfg_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   depth_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output wfrf_pkg::job_t                    push_job_o
);
  import wfrf_pkg::*;

  logic       ch_ok;
  logic [1:0] mode;
  logic [7:0] limit;
  logic       pct_ok;
  logic       seq_ok;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign ch_ok = ({1'b0, in_item_i.channel} < 5'(NUM_CHANNELS));
  assign mode  = cfg_i.mode_table[{in_item_i.channel, 1'b0} +: 2];
  assign limit = cfg_i.limits[{in_item_i.channel, 3'b000} +: 8];

  assign pct_ok = (mode == MODE_PCT) && (limit != 8'd0) &&
                  (limit <= 8'(PERCENT_FULL));
  assign seq_ok = (mode == MODE_SEQ) && (limit != 8'd0);

  always_comb begin
    push_job_o.channel     = in_item_i.channel;
    push_job_o.test_failed = in_item_i.test_failed;
    push_job_o.thr         = '0;
    if (!(cfg_i.enable && ch_ok)) begin
      push_job_o.kind = JOB_RAW;
    end else if (pct_ok) begin
      // floor(fails*100/d) >= limit is fails*100 >= limit*d
      push_job_o.kind = JOB_PCT;
      push_job_o.thr  = THR_W'(limit) * THR_W'(depth_i);
    end else if (seq_ok) begin
      // sequence limit clamped to the window
      push_job_o.kind = JOB_SEQ;
      push_job_o.thr  = (THR_W'(limit) > THR_W'(depth_i)) ? THR_W'(depth_i) : THR_W'(limit);
    end else begin
      push_job_o.kind = JOB_KEEP;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wfrf_queue.sv =====
// short job queue between the front and back ends
`default_nettype none

module wfrf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  wfrf_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wfrf_pkg::job_t pop_job_o
);
  import wfrf_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push;
  logic          pop;

  assign push_ready_o = (count_q != CW'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wfrf_back.sv =====
// back end: history store, one-bit-per-cycle window scan and result register
`default_nettype none
`include "windowed_fault_result_filter_unit_defines.svh"

module wfrf_back #(
  parameter int unsigned NUM_CHANNELS = wfrf_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW   = wfrf_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] depth_i,
  input  logic                            clr_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  wfrf_pkg::job_t                  q_job_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wfrf_pkg::out_item_t             out_item_o
);
  import wfrf_pkg::*;

  localparam int unsigned DW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CIW = $clog2(NUM_CHANNELS);

  logic [MAX_WINDOW-1:0] hist_q [NUM_CHANNELS];
  logic [MAX_WINDOW-1:0] mask;
  logic [MAX_WINDOW-1:0] row_new;
  logic [MAX_WINDOW-1:0] scan_q;
  back_state_e           state_q, state_d;
  job_kind_e             kind_q;
  logic [THR_W-1:0]      thr_q;
  logic [DW-1:0]         cnt_q, fails_q, run_q, best_q;
  logic [DW-1:0]         run_nx;
  logic                  verdict_q, applied_q;
  logic [CIW-1:0]        ch_idx;
  logic                  pop, scan_en, judge_en, emit_load;
  logic                  last_bit, bit_now, judge_fail;
  logic [THR_W-1:0]      pct_prod;
  logic                  out_valid_q;
  out_item_t             out_q;

  // positions at or beyond the depth read as pass
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      mask[i] = (DW'(i) < depth_i);
    end
  end

  assign ch_idx   = q_job_i.channel[CIW-1:0];
  assign row_new  = {hist_q[ch_idx][MAX_WINDOW-2:0], q_job_i.test_failed} & mask;
  assign bit_now  = scan_q[0];
  assign run_nx   = bit_now ? run_q + DW'(1) : '0;
  assign last_bit = (cnt_q == depth_i - DW'(1));
  assign pct_prod = THR_W'(fails_q) * THR_W'(PERCENT_FULL);
  assign judge_fail = (kind_q == JOB_PCT) ? (pct_prod >= thr_q) : (THR_W'(best_q) >= thr_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_job_i.kind == JOB_PCT || q_job_i.kind == JOB_SEQ) ? BK_SCAN : BK_EMIT;
        end
      end
      BK_SCAN: begin
        if (last_bit) begin
          state_d = BK_JUDGE;
        end
      end
      BK_JUDGE: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_ready_o = (state_q == BK_IDLE);
    pop       = q_ready_o && q_valid_i;
    scan_en   = (state_q == BK_SCAN);
    judge_en  = (state_q == BK_JUDGE);
    emit_load = (state_q == BK_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_CHANNELS; r++) begin
        hist_q[r] <= '0;
      end
    end else if (clr_i) begin
      for (int r = 0; r < NUM_CHANNELS; r++) begin
        hist_q[r] <= hist_q[r] & mask;
      end
    end else if (pop && q_job_i.kind != JOB_RAW) begin
      hist_q[ch_idx] <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fails_q <= '0;
      run_q   <= '0;
      best_q  <= '0;
    end else if (pop) begin
      cnt_q   <= '0;
      fails_q <= '0;
      run_q   <= '0;
      best_q  <= '0;
    end else if (scan_en) begin
      cnt_q   <= cnt_q + DW'(1);
      fails_q <= fails_q + DW'(bit_now);
      run_q   <= run_nx;
      if (run_nx > best_q) begin
        best_q <= run_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      scan_q    <= row_new;
      kind_q    <= q_job_i.kind;
      thr_q     <= q_job_i.thr;
      verdict_q <= q_job_i.test_failed;
      applied_q <= 1'b0;
    end else if (scan_en) begin
      scan_q <= scan_q >> 1;
    end else if (judge_en) begin
      verdict_q <= judge_fail;
      applied_q <= 1'b1;
    end
  end

  // result register decouples the scan from the output side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_q.filtered_failed <= verdict_q;
      out_q.filter_applied  <= applied_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `WFRF_ASSERT_IMP(a_scan_in_window, state_q == BK_SCAN, cnt_q < depth_i)
  `WFRF_ASSERT_IMP(a_fails_le_count, state_q == BK_SCAN, fails_q <= cnt_q)
  `WFRF_ASSERT_IMP(a_best_le_fails, state_q == BK_SCAN, best_q <= fails_q)
  `WFRF_ASSERT_NXT(a_emit_fills_output, emit_load, out_valid_q)

endmodule

`default_nettype wire

// ===== sv/windowed_fault_result_filter_unit.sv =====
// top level of the windowed fault result filter: config registers and datapath
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o | in_item_i  (channel, test_failed)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (filtered_failed,
//          |           |                       |   filter_applied)
//  cfg     | input     | psel/penable/pwrite   | paddr, pwdata, prdata (64 bit)
//
//  a filtered item passes the back end in these steps: pop and shift the
//  channel history, walk the window one bit a cycle, judge, load the result
//  register; raw and unfiltered items go from the pop straight to the load
//  the single scan unit in the back end sets the rate; the two-entry queue keeps
//  taking items while it scans, and the result register holds under a stall
//  no clearing pass after reset: the history flops reset to pass at once
//  a window_depth write clears positions beyond the new depth in the cycle after
`default_nettype none

module windowed_fault_result_filter_unit #(
  parameter int unsigned NUM_CHANNELS = wfrf_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW   = wfrf_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wfrf_pkg::in_item_t             in_item_i,
  // item output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wfrf_pkg::out_item_t            out_item_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wfrf_pkg::PADDR_W-1:0]   paddr,
  input  logic [wfrf_pkg::PDATA_W-1:0]   pwdata,
  output logic [wfrf_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import wfrf_pkg::*;

  localparam int unsigned DW = $clog2(MAX_WINDOW + 1);

  // configuration registers
  logic        enable_q;
  logic [7:0]  window_depth_q;
  logic [31:0] mode_table_q;
  logic [63:0] limit_lo_q;
  logic [63:0] limit_hi_q;
  logic        clr_q;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [7:0]           depth_raw;
  logic [DW-1:0]        depth;
  cfg_t                 cfg;

  // front to queue to back
  logic push_valid, push_ready;
  job_t push_job;
  logic q_valid, q_ready;
  job_t q_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // registers sit 8 bytes apart since two of them are 64 bits wide
  assign reg_idx = paddr[PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      window_depth_q <= 8'(DEPTH_DEFAULT);
      mode_table_q   <= '0;
      limit_lo_q     <= '0;
      limit_hi_q     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:   enable_q       <= pwdata[0];
        REG_DEPTH:    window_depth_q <= pwdata[7:0];
        REG_MODE:     mode_table_q   <= pwdata[31:0];
        REG_LIMIT_LO: limit_lo_q     <= pwdata;
        REG_LIMIT_HI: limit_hi_q     <= pwdata;
        default: begin
          // addresses beyond the register list are ignored
        end
      endcase
    end
  end

  // one-cycle pulse that trims every history row to the new depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b0;
    end else begin
      clr_q <= wr_en && (reg_idx == REG_DEPTH);
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENABLE:   prdata = PDATA_W'(enable_q);
      REG_DEPTH:    prdata = PDATA_W'(window_depth_q);
      REG_MODE:     prdata = PDATA_W'(mode_table_q);
      REG_LIMIT_LO: prdata = limit_lo_q;
      REG_LIMIT_HI: prdata = limit_hi_q;
      default:      prdata = '0;
    endcase
  end

  // effective depth: zero means the default, then saturate to the window size
  assign depth_raw = (window_depth_q == 8'd0) ? 8'(DEPTH_DEFAULT) : window_depth_q;
  assign depth     = ({1'b0, depth_raw} > 9'(MAX_WINDOW)) ? DW'(MAX_WINDOW) : DW'(depth_raw);

  assign cfg.enable     = enable_q;
  assign cfg.mode_table = mode_table_q;
  assign cfg.limits     = {limit_hi_q, limit_lo_q};

  wfrf_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_i        (cfg),
    .depth_i      (depth),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  wfrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_job_o    (q_job)
  );

  wfrf_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .depth_i     (depth),
    .clr_i       (clr_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_job_i     (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_windowed_fault_result_filter_unit.sv =====
// self-checking testbench of the windowed fault result filter unit
module tb_windowed_fault_result_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wfrf_pkg::*;

  localparam int unsigned NUM_CH     = NUM_CHANNELS_DEF;
  localparam int unsigned MAX_WIN    = MAX_WINDOW_DEF;
  // random items after the directed table
  localparam int unsigned RAND_ITEMS = 530;
  // hold-off at the end, a little over the slowest back-end pass
  localparam int unsigned DRAIN_CYC  = MAX_WINDOW_DEF + 12;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  windowed_fault_result_filter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and of every channel's history
  // ---------------------------------------------------------------------------
  logic         en_r;
  logic [7:0]   depth_r;
  logic [31:0]  mode_r;
  logic [63:0]  lim_lo_r;
  logic [63:0]  lim_hi_r;
  // bit 0 is the newest result, 1 means failed
  logic [127:0] hist [NUM_CH];

  out_item_t    verdict_q [$];
  int unsigned  err_cnt;
  int unsigned  items_sent;
  int unsigned  results_seen;
  int unsigned  rule_hits;
  int unsigned  reg_writes;
  int unsigned  phases;
  // no idling on either side while set
  bit           calm;

  // window actually judged: zero means the default, large values saturate
  function automatic int unsigned window_len();
    int unsigned d;
    d = 32'(depth_r);
    if (d == 0) d = DEPTH_DEFAULT;
    if (d > MAX_WIN) d = MAX_WIN;
    return d;
  endfunction

  function automatic logic [127:0] window_mask(int unsigned d);
    if (d >= 128) return {128{1'b1}};
    return (128'd1 << d) - 128'd1;
  endfunction

  function automatic void apply_reg_write(reg_idx_e idx, logic [63:0] v);
    logic [127:0] m;
    case (idx)
      REG_ENABLE:   en_r = v[0];
      REG_DEPTH: begin
        depth_r = v[7:0];
        // a new depth drops everything beyond it in every channel
        m = window_mask(window_len());
        for (int c = 0; c < NUM_CH; c++) hist[c] &= m;
      end
      REG_MODE:     mode_r = v[31:0];
      REG_LIMIT_LO: lim_lo_r = v;
      REG_LIMIT_HI: lim_hi_r = v;
      default: ;
    endcase
  endfunction

  // when filtering is enabled, shifts the outcome into the history and judges the window
  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t    r;
    int unsigned  d;
    int unsigned  fails;
    int unsigned  run;
    int unsigned  best;
    int unsigned  lim;
    mode_e        md;
    logic [127:0] h;
    r.filtered_failed = it.test_failed;
    r.filter_applied  = 1'b0;
    if (en_r && it.channel < NUM_CH) begin
      d  = window_len();
      h  = ((hist[it.channel] << 1) | {127'd0, it.test_failed}) & window_mask(d);
      hist[it.channel] = h;
      md = mode_e'(mode_r[2*it.channel +: 2]);
      if (it.channel < 8) lim = 32'(lim_lo_r[8*it.channel +: 8]);
      else                lim = 32'(lim_hi_r[8*(it.channel-8) +: 8]);
      fails = 0;
      run   = 0;
      best  = 0;
      for (int i = 0; i < d; i++) begin
        fails += 32'(h[i]);
        run = h[i] ? run + 1 : 0;
        if (run > best) best = run;
      end
      if (md == MODE_PCT && lim > 0 && lim <= PERCENT_FULL) begin
        r.filtered_failed = ((fails * PERCENT_FULL) / d >= lim);
        r.filter_applied  = 1'b1;
      end else if (md == MODE_SEQ && lim > 0) begin
        // a run longer than the window can never happen, so clamp the limit
        if (lim > d) lim = d;
        r.filtered_failed = (best >= lim);
        r.filter_applied  = 1'b1;
      end
    end
    return r;
  endfunction

  // gap length: mostly short, a few long, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 93) return $urandom_range(3, 12);
    return $urandom_range(40, 300);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: input item channel and register port
  // ---------------------------------------------------------------------------
  // valid stays high when the next item follows with no gap
  task automatic send_item(in_item_t it, int unsigned gap, bit known, out_item_t res);
    out_item_t guess;
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = predict_verdict(it);
    // rows with a typed-in answer check that answer instead of the predictor's
    verdict_q.push_back(known ? res : guess);
    items_sent++;
  endtask

  // registers move only when every expected result has come out
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // write, then read back through a second transfer
  task automatic reg_write(reg_idx_e idx, logic [63:0] v);
    logic [63:0] keep;
    case (idx)
      REG_ENABLE: keep = 64'h1;
      REG_DEPTH:  keep = 64'hFF;
      REG_MODE:   keep = 64'hFFFF_FFFF;
      default:    keep = {64{1'b1}};
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    apply_reg_write(idx, v);
    reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== (v & keep)) begin
      $error("prdata of %s: expected %h, got %h", idx.name(), v & keep, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and the field by field check
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("result with nothing expected: filtered_failed %b, filter_applied %b",
               out_item_o.filtered_failed, out_item_o.filter_applied);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        rule_hits += 32'(want.filter_applied);
        if (out_item_o.filtered_failed !== want.filtered_failed) begin
          $error("filtered_failed: expected %b, got %b",
                 want.filtered_failed, out_item_o.filtered_failed);
          err_cnt++;
        end
        if (out_item_o.filter_applied !== want.filter_applied) begin
          $error("filter_applied: expected %b, got %b",
                 want.filter_applied, out_item_o.filter_applied);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table: register writes and items, answers typed in where obvious
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        wr;      // 1: register write, 0: item
    reg_idx_e    ridx;
    logic [63:0] val;
    logic [3:0]  ch;
    logic        fail;
    logic        known;   // typed-in answer below is checked
    logic        exp_ff;
    logic        exp_fa;
  } dir_row_t;

  // mode table: ch0 percentage, ch1 sequence, ch2 mode 3, ch3 none,
  // ch4 and ch5 percentage, ch6 and ch15 sequence
  // limits: ch0 100, ch1 3, ch4 zero, ch5 101, ch6 zero, ch15 255
  localparam int unsigned DIR_ROWS = 34;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // after reset filtering is off, raw outcome out
    '{1'b0, REG_ENABLE,   64'd0,                  4'd0,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd15, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, REG_ENABLE,   64'd1,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_MODE,     64'h0000_0000_8000_2539, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_LIMIT_LO, 64'h0000_6500_0505_0364, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_LIMIT_HI, 64'hFF80_0000_0000_0001, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0},
    // one-deep window: every rule sees only the newest outcome
    '{1'b1, REG_DEPTH,    64'd1,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd0,  1'b1, 1'b1, 1'b1, 1'b1},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b1, 1'b1, 1'b1, 1'b1},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd2,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd3,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd4,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd5,  1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd6,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd15, 1'b1, 1'b1, 1'b1, 1'b1},
    // depth zero falls back to the default window
    '{1'b1, REG_DEPTH,    64'd0,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd15, 1'b0, 1'b1, 1'b0, 1'b1},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b1, 1'b0, 1'b0, 1'b0},
    // too large saturates to the full window
    '{1'b1, REG_DEPTH,    64'd200,                4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd15, 1'b1, 1'b0, 1'b0, 1'b0},
    // shrinking the window clears the older history
    '{1'b1, REG_DEPTH,    64'd3,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    // disabled again: raw out, no history update
    '{1'b1, REG_ENABLE,   64'd0,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b1, REG_ENABLE,   64'd1,                  4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_DEPTH,    64'd128,                4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd6,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd9,  1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_DEPTH,    64'd255,                4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_ENABLE,   64'd0,                  4'd1,  1'b1, 1'b0, 1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t     it;
    out_item_t    res;
    int unsigned  rand_items;
    int unsigned  d;
    int unsigned  n;
    int unsigned  pf;
    int unsigned  hot;
    int unsigned  r;
    logic [63:0]  lim;
    logic [7:0]   b;

    // everything known from time zero while reset is held low
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    err_cnt    = 0;
    items_sent = 0;
    results_seen = 0;
    rule_hits  = 0;
    reg_writes = 0;
    phases     = 0;
    rand_items = 0;
    // predictor mirrors the reset values
    en_r     = 1'b0;
    depth_r  = 8'(DEPTH_DEFAULT);
    mode_r   = '0;
    lim_lo_r = '0;
    lim_hi_r = '0;
    for (int c = 0; c < NUM_CH; c++) hist[c] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].wr) begin
        settle();
        reg_write(DIR_TAB[i].ridx, DIR_TAB[i].val);
      end else begin
        it.channel          = DIR_TAB[i].ch;
        it.test_failed      = DIR_TAB[i].fail;
        res.filtered_failed = DIR_TAB[i].exp_ff;
        res.filter_applied  = DIR_TAB[i].exp_fa;
        send_item(it, pick_gap(), DIR_TAB[i].known, res);
      end
    end

    // random phases: new register setting, then a burst of items
    res = '0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      phases++;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 6) reg_write(REG_ENABLE, {63'd0, $urandom_range(0, 9) != 0});
      if ($urandom_range(0, 9) < 8) begin
        // mostly short windows so the scan stays quick, a few full ones
        r = $urandom_range(0, 99);
        if      (r < 55) d = $urandom_range(1, 8);
        else if (r < 75) d = $urandom_range(9, 24);
        else if (r < 82) d = 0;
        else if (r < 90) d = $urandom_range(25, 127);
        else if (r < 95) d = 128;
        else             d = $urandom_range(129, 255);
        reg_write(REG_DEPTH, 64'(d));
      end
      d = window_len();
      if ($urandom_range(0, 9) < 7) reg_write(REG_MODE, {32'd0, $urandom()});
      for (int t = 0; t < 2; t++) begin
        if ($urandom_range(0, 9) < 7) begin
          // per channel: valid percentages, limits near the window, zero,
          // above 100, or anything
          for (int k = 0; k < 8; k++) begin
            r = $urandom_range(0, 99);
            if      (r < 35) b = 8'($urandom_range(1, 100));
            else if (r < 70) b = 8'($urandom_range(1, (d + 2 > 255) ? 255 : d + 2));
            else if (r < 80) b = 8'd0;
            else if (r < 90) b = 8'($urandom_range(101, 255));
            else             b = 8'($urandom_range(0, 255));
            lim[8*k +: 8] = b;
          end
          reg_write(t == 0 ? REG_LIMIT_LO : REG_LIMIT_HI, lim);
        end
      end

      // fail rate and a hot pair of channels per phase, so windows fill up
      n = (d > 40) ? $urandom_range(10, 20) : $urandom_range(25, 45);
      case ($urandom_range(0, 4))
        0:       pf = 5;
        1:       pf = 30;
        2:       pf = 50;
        3:       pf = 80;
        default: pf = 97;
      endcase
      hot = $urandom_range(0, 15);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 7) it.channel = 4'(hot ^ $urandom_range(0, 1));
        else                          it.channel = 4'($urandom_range(0, 15));
        it.test_failed = ($urandom_range(0, 99) < pf);
        send_item(it, pick_gap(), 1'b0, res);
        rand_items++;
      end
    end

    // drain, then a hold-off for anything the block should not send
    settle();
    calm = 1'b0;
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d items over %0d random register phases, %0d register writes",
             items_sent, phases, reg_writes);
    $display("%0d results compared, %0d decided by a percentage or sequence rule",
             results_seen, rule_hits);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("watchdog expired, %0d results still expected", verdict_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
